FILE: design/rebr_pkg.sv
`timescale 1ns / 1ps
// Package for the byte-renormalizing range encoder.
// Holds payload types, operation and register codes, and shared constants.
package rebr_pkg;

    localparam int PENDING_BITS_DEF = 32;
    localparam int MAX_ITEMS        = 12;
    localparam int ITEM_IDX_W       = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] CFG_FAST_MODE     = 2'd0;
    localparam logic [1:0] CFG_FIRST_BYTE    = 2'd1;
    localparam logic [1:0] CFG_INITIAL_COUNT = 2'd2;

    localparam logic [31:0] TOP_VAL    = 32'h8000_0000;
    localparam logic [31:0] BOTTOM_VAL = 32'h0080_0000;
    localparam logic [31:0] CARRY_LIM  = 32'h7f80_0000;
    localparam logic [31:0] FIN_ROUND  = 32'd5;
    localparam logic [1:0]  MAX_STEPS  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] cum_freq;
        logic [16:0] symbol_freq;
        logic [16:0] total_freq;
    } t_in;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [31:0] run_length;
        logic        last;
        logic        pending_overflow;
        logic [31:0] bytes_written;
    } t_out;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [31:0] run_length;
    } t_item;

    typedef struct packed {
        logic valid;
        t_in  data;
    } t_queue_head;

endpackage

FILE: design/rebr_front.sv
`timescale 1ns / 1ps
// Front end of the range encoder: accepts transactions, drops ignored ones,
// queues the rest for the back end. Depends on rebr_pkg.
module rebr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  rebr_pkg::t_in         i_data,
    output rebr_pkg::t_queue_head o_head,
    input  logic                  i_pop
);
    localparam int PW = $clog2(rebr_pkg::QUEUE_DEPTH);

    rebr_pkg::t_in r_mem [rebr_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          keep, push, pop;

    always_comb begin
        keep = (i_data.operation == rebr_pkg::OP_START) ||
               (i_data.operation == rebr_pkg::OP_FINISH) ||
               ((i_data.operation == rebr_pkg::OP_ENCODE) && (i_data.total_freq != 17'd0));
    end

    assign o_stall     = (r_cnt == (PW+1)'(rebr_pkg::QUEUE_DEPTH));
    assign push        = i_valid && !o_stall && keep;
    assign pop         = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

FILE: design/rebr_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider, 32-bit dividend by 17-bit divisor, one bit a cycle.
// Standalone; no package use beyond widths fixed here.
module rebr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    logic [31:0] r_quo;
    logic [16:0] r_rem, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] trial, diff;

    assign trial = {r_rem, r_quo[31]};
    assign diff  = trial - {1'b0, r_dvs};
    assign o_done     = r_busy && (r_cnt == 6'd32);
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy && !o_done) begin
            if (!diff[17]) begin
                r_rem <= diff[16:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial[16:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end
endmodule

FILE: design/rebr_back.sv
`timescale 1ns / 1ps
// Back end of the range encoder: coder state, renormalization sequencer,
// result buffer and output register. Depends on rebr_pkg and rebr_div.
module rebr_back #(
    parameter int PENDING_BITS = rebr_pkg::PENDING_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rebr_pkg::t_queue_head i_head,
    output logic                  o_pop,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rebr_pkg::t_out        o_data
);
    localparam logic [3:0] S_IDLE = 4'd0,  S_RN   = 4'd1,  S_FL0  = 4'd2,  S_FL1 = 4'd3,
                           S_STEP = 4'd4,  S_DIV  = 4'd5,  S_MUL1 = 4'd6,  S_MUL2 = 4'd7,
                           S_UPD  = 4'd8,  S_FIN0 = 4'd9,  S_FIN1 = 4'd10, S_T0  = 4'd11,
                           S_T1   = 4'd12, S_T2   = 4'd13, S_T3   = 4'd14, S_OUT = 4'd15;
    localparam int IW = rebr_pkg::ITEM_IDX_W;

    logic        r_fast;
    logic [7:0]  r_first;
    logic [31:0] r_init;

    logic [3:0]              r_state;
    logic [31:0]             r_low, r_range, r_bc, r_q, r_t, r_s;
    logic [7:0]              r_held, r_tail;
    logic [PENDING_BITS-1:0] r_pend;
    logic                    r_ovf, r_carry, r_fl_fin, r_fin;
    logic [1:0]              r_steps;
    rebr_pkg::t_in           r_op;
    rebr_pkg::t_item         r_buf [rebr_pkg::MAX_ITEMS];
    logic [IW-1:0]           r_n, r_rd;
    logic                    r_ov;
    rebr_pkg::t_out          r_out;

    logic        div_start, div_done;
    logic [31:0] div_q;
    logic        wr_en;
    rebr_pkg::t_item wr_item;
    logic        load, need_step;
    logic [9:0]  tail;
    logic [17:0] lt_sy;

    rebr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_range),
        .i_divisor  (r_op.total_freq),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_pop     = (r_state == S_IDLE) && i_head.valid;
    assign need_step = (r_steps != rebr_pkg::MAX_STEPS) && (r_range <= rebr_pkg::BOTTOM_VAL);
    assign div_start = (r_state == S_RN) && !need_step && (r_op.operation == rebr_pkg::OP_ENCODE);
    assign load      = (r_state == S_OUT) && (!r_ov || !i_stall);
    assign tail      = 10'(r_low[31:23]) +
                       10'(({9'd0, r_low[22:0]} >= {1'b0, r_bc[31:1]}) ? 1'b1 : 1'b0);
    assign lt_sy     = 18'(r_op.cum_freq) + 18'(r_op.symbol_freq);
    assign o_valid   = r_ov;
    assign o_data    = r_out;

    // result item written into the buffer by the current state
    always_comb begin
        wr_en   = 1'b0;
        wr_item = '0;
        unique case (r_state)
            S_FL0: begin
                wr_en = 1'b1;
                wr_item.byte_value = r_carry ? (r_held + 8'd1) : r_held;
                wr_item.run_length = 32'd1;
            end
            S_FL1: begin
                wr_en = 1'b1;
                wr_item.byte_value = r_carry ? 8'h00 : 8'hff;
                wr_item.run_length = 32'(r_pend);
            end
            S_T0: begin
                wr_en = 1'b1;
                wr_item = {r_tail, 32'd1};
            end
            S_T1: begin
                wr_en = 1'b1;
                wr_item = {r_bc[23:16], 32'd1};
            end
            S_T2: begin
                wr_en = 1'b1;
                wr_item = {r_bc[15:8], 32'd1};
            end
            S_T3: begin
                wr_en = 1'b1;
                wr_item = {r_bc[7:0], 32'd1};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_n] <= wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast <= 1'b1;
            r_first <= '0;
            r_init <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rebr_pkg::CFG_FAST_MODE:     r_fast  <= i_cfg_data[0];
                rebr_pkg::CFG_FIRST_BYTE:    r_first <= i_cfg_data[7:0];
                rebr_pkg::CFG_INITIAL_COUNT: r_init  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_range  <= rebr_pkg::TOP_VAL;
            r_held   <= '0;
            r_pend   <= '0;
            r_bc     <= '0;
            r_ovf    <= 1'b0;
            r_n      <= '0;
            r_rd     <= '0;
            r_ov     <= 1'b0;
            r_steps  <= '0;
            r_carry  <= 1'b0;
            r_fl_fin <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            if (wr_en) r_n <= r_n + 1'b1;
            // output register: refill from buffer or drop when taken
            if (load) begin
                r_ov <= 1'b1;
                r_out.byte_value       <= r_buf[r_rd].byte_value;
                r_out.run_length       <= r_buf[r_rd].run_length;
                r_out.last             <= (r_rd == r_n - 1'b1);
                r_out.pending_overflow <= r_ovf;
                r_out.bytes_written    <= (r_fin && (r_rd == r_n - 1'b1)) ? r_bc : 32'd0;
                r_rd <= r_rd + 1'b1;
                if (r_rd == r_n - 1'b1) r_state <= S_IDLE;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_op     <= i_head.data;
                        r_n      <= '0;
                        r_rd     <= '0;
                        r_steps  <= '0;
                        r_fl_fin <= 1'b0;
                        r_fin    <= (i_head.data.operation == rebr_pkg::OP_FINISH);
                        if (i_head.data.operation == rebr_pkg::OP_START) begin
                            r_low   <= '0;
                            r_range <= rebr_pkg::TOP_VAL;
                            r_held  <= r_first;
                            r_pend  <= '0;
                            r_bc    <= r_init;
                            r_ovf   <= 1'b0;
                        end else begin
                            r_state <= S_RN;
                        end
                    end
                end
                S_RN: begin
                    if (need_step) begin
                        if (r_low < rebr_pkg::CARRY_LIM) begin
                            r_carry <= 1'b0;
                            r_state <= S_FL0;
                        end else if (r_low[31]) begin
                            r_carry <= 1'b1;
                            r_state <= S_FL0;
                        end else begin
                            if (&r_pend) r_ovf <= 1'b1;
                            else         r_pend <= r_pend + 1'b1;
                            r_state <= S_STEP;
                        end
                    end else if (r_op.operation == rebr_pkg::OP_ENCODE) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_FIN0;
                    end
                end
                S_FL0, S_FL1: begin
                    if (r_state == S_FL0 && r_pend != '0) begin
                        r_state <= S_FL1;
                    end else begin
                        r_pend <= '0;
                        if (r_fl_fin) begin
                            r_state <= S_T0;
                        end else begin
                            r_held  <= r_low[30:23];
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_range <= {r_range[23:0], 8'd0};
                    r_low   <= {1'b0, r_low[22:0], 8'd0};
                    r_bc    <= r_bc + 32'd1;
                    r_steps <= r_steps + 2'd1;
                    r_state <= S_RN;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_q     <= div_q;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_t     <= 32'(r_q * 32'(r_op.cum_freq));
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_s     <= 32'(r_q * 32'(r_op.symbol_freq));
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_low <= r_low + r_t;
                    if (r_fast || (lt_sy < 18'(r_op.total_freq))) r_range <= r_s;
                    else                                          r_range <= r_range - r_t;
                    r_state <= (r_n == '0) ? S_IDLE : S_OUT;
                end
                S_FIN0: begin
                    r_bc    <= r_bc + rebr_pkg::FIN_ROUND;
                    r_state <= S_FIN1;
                end
                S_FIN1: begin
                    r_carry  <= (tail[9:8] != 2'd0);
                    r_tail   <= tail[7:0];
                    r_fl_fin <= 1'b1;
                    r_state  <= S_FL0;
                end
                S_T0: r_state <= S_T1;
                S_T1: r_state <= S_T2;
                S_T2: r_state <= S_T3;
                S_T3: r_state <= S_OUT;
                S_OUT: begin
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_buf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= IW'(rebr_pkg::MAX_ITEMS))
        else $error("result buffer overrun");
    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_n != '0))
        else $error("drain with empty buffer");
    a_tail_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T0) |-> (r_pend == '0))
        else $error("pending run left after finish flush");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("quotient outside divide state");
endmodule

FILE: design/range_encoder_byte_renorm_top.sv
`timescale 1ns / 1ps
// Range encoder top level; depends on rebr_pkg, rebr_front, rebr_back, rebr_div.
// Encode: renorm steps (each flushing the held byte and any pending run where needed),
// then the radix-2 divider, two multiplies and the update; finish: renorm steps, then
// rounding, the final flush, the tail byte and three count bytes. The back end takes one
// transaction at a time and drains its results from the buffer before it takes the next.
// Reset (i_rst_n low, synchronous) resets the queue, coder state and config.
module range_encoder_byte_renorm_top #(
    parameter int PENDING_BITS = rebr_pkg::PENDING_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // input transaction channel
    input  logic           i_valid,
    output logic           o_stall,
    input  rebr_pkg::t_in  i_data,
    // result transaction channel
    output logic           o_valid,
    input  logic           i_stall,
    output rebr_pkg::t_out o_data,
    // configuration writes, only while idle
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);
    // front drops ignored operations and buffers the rest in a short queue
    rebr_pkg::t_queue_head head;
    logic                  pop;

    rebr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_head  (head),
        .i_pop   (pop)
    );

    // back end runs renorm, divide, multiply and result drain
    rebr_back #(
        .PENDING_BITS (PENDING_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for range_encoder_byte_renorm_top: directed and random coder sessions.
// Predicts each byte run on the side and compares it with every result transaction.
// Depends on rebr_pkg and the encoder top level.
module tb_top;

    // Watchdog: cycles with no accepted transaction on either side.
    localparam int IDLE_LIMIT = 20000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    rebr_pkg::t_in         i_data;
    logic                  o_valid;
    logic                  i_stall;
    rebr_pkg::t_out        o_data;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [31:0]           i_cfg_data;

    range_encoder_byte_renorm_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // Shadow of the encoder configuration and coder state.
    logic        sh_fast;
    logic [7:0]  sh_first;
    logic [31:0] sh_init_cnt;
    logic [31:0] sh_low;
    logic [31:0] sh_range;
    logic [7:0]  sh_held;
    logic [31:0] sh_pend;
    logic [31:0] sh_count;
    logic        sh_ovf;

    rebr_pkg::t_out expected_runs[$];
    rebr_pkg::t_out pend_runs[$];
    int   mismatches;
    int   idle_cycles;
    bit   hold_off;      // long receiver hold-off request
    bit   rx_free;       // disable receiver stalls

    // Collect one run; flags are patched when the input's result list is complete.
    task automatic put_run(input logic [7:0] v, input logic [31:0] len);
        rebr_pkg::t_out r;
        r = '0;
        r.byte_value = v;
        r.run_length = len;
        pend_runs.push_back(r);
    endtask

    task automatic flush_held_byte(input bit carry);
        if (carry) begin
            put_run(sh_held + 8'd1, 32'd1);
            if (sh_pend != 0) put_run(8'h00, sh_pend);
        end else begin
            put_run(sh_held, 32'd1);
            if (sh_pend != 0) put_run(8'hff, sh_pend);
        end
        sh_pend = 0;
    endtask

    task automatic renormalize();
        for (int s = 0; s < 3; s++) begin
            if (sh_range > rebr_pkg::BOTTOM_VAL) break;
            if (sh_low < rebr_pkg::CARRY_LIM) begin
                flush_held_byte(1'b0);
                sh_held = sh_low[30:23];
            end else if (sh_low[31]) begin
                flush_held_byte(1'b1);
                sh_held = sh_low[30:23];
            end else if (sh_pend == 32'hffff_ffff) begin
                sh_ovf = 1'b1;
            end else begin
                sh_pend++;
            end
            sh_range = sh_range << 8;
            sh_low   = (sh_low << 8) & 32'h7fff_ffff;
            sh_count = sh_count + 32'd1;
        end
    endtask

    // Advance the shadow coder by one input and queue its byte runs.
    task automatic predict_runs(input rebr_pkg::t_in it);
        logic [31:0] r, t, tail;
        pend_runs.delete();
        if (it.operation == rebr_pkg::OP_START) begin
            sh_low = 0; sh_range = rebr_pkg::TOP_VAL; sh_held = sh_first;
            sh_pend = 0; sh_count = sh_init_cnt; sh_ovf = 0;
        end else if (it.operation == rebr_pkg::OP_ENCODE && it.total_freq != 0) begin
            renormalize();
            r = sh_range / {15'd0, it.total_freq};
            t = r * {16'd0, it.cum_freq};
            sh_low = sh_low + t;
            if (sh_fast || ({16'd0, it.cum_freq} + {15'd0, it.symbol_freq}
                            < {15'd0, it.total_freq}))
                sh_range = r * {15'd0, it.symbol_freq};
            else
                sh_range = sh_range - t;
        end else if (it.operation == rebr_pkg::OP_FINISH) begin
            renormalize();
            sh_count = sh_count + rebr_pkg::FIN_ROUND;
            tail = sh_low >> 23;
            if ((sh_low & (rebr_pkg::BOTTOM_VAL - 32'd1)) >= (sh_count >> 1))
                tail = tail + 32'd1;
            flush_held_byte(tail > 32'hff);
            put_run(tail[7:0], 32'd1);
            put_run(sh_count[23:16], 32'd1);
            put_run(sh_count[15:8], 32'd1);
            put_run(sh_count[7:0], 32'd1);
            pend_runs[pend_runs.size()-1].bytes_written = sh_count;
        end
        foreach (pend_runs[k]) begin
            pend_runs[k].pending_overflow = sh_ovf;
            pend_runs[k].last = (k == pend_runs.size() - 1);
            expected_runs.push_back(pend_runs[k]);
        end
    endtask

    // Offer one transaction; hold it until accepted, then predict.
    // Valid stays high; the gap or drain that follows drops it.
    task automatic send_item(input rebr_pkg::t_in it);
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_runs(it);
    endtask

    task automatic send_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic rebr_pkg::t_in make_enc(input logic [15:0] c, input logic [16:0] s,
                                               input logic [16:0] t);
        rebr_pkg::t_in it;
        it.operation = rebr_pkg::OP_ENCODE;
        it.cum_freq = c; it.symbol_freq = s; it.total_freq = t;
        return it;
    endfunction

    function automatic rebr_pkg::t_in make_op(input logic [1:0] op);
        rebr_pkg::t_in it;
        it = '0;
        it.operation = op;
        it.cum_freq = 16'($urandom);
        it.symbol_freq = 17'($urandom);
        it.total_freq = 17'($urandom);
        return it;
    endfunction

    // Well-formed symbol: cum + sym <= total, mostly small totals.
    function automatic rebr_pkg::t_in rand_symbol();
        logic [16:0] t, s, c;
        case ($urandom_range(0, 3))
            0: t = 17'd1 << $urandom_range(0, 16);
            1: t = 17'($urandom_range(1, 65536));
            default: t = 17'($urandom_range(1, 300));
        endcase
        c = (t > 1) ? 17'($urandom_range(0, (t > 65536 ? 65535 : t - 1))) : 17'd0;
        if (c > 65535) c = 17'd65535;
        s = 17'($urandom_range(1, t - c));
        return make_enc(c[15:0], s, t);
    endfunction

    // Wait for every expectation, then let the back end settle before config writes.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            rebr_pkg::CFG_FAST_MODE:     sh_fast = val[0];
            rebr_pkg::CFG_FIRST_BYTE:    sh_first = val[7:0];
            rebr_pkg::CFG_INITIAL_COUNT: sh_init_cnt = val;
            default: ;
        endcase
    endtask

    task automatic test_directed();
        write_cfg(rebr_pkg::CFG_FAST_MODE, 32'd0);
        write_cfg(rebr_pkg::CFG_FIRST_BYTE, 32'hff);
        write_cfg(rebr_pkg::CFG_INITIAL_COUNT, 32'hffff_fffd);
        send_item(make_op(rebr_pkg::OP_START));
        send_item(make_enc(16'd0, 17'd1, 17'd65536));       // tiny range
        send_item(make_enc(16'hffff, 17'd1, 17'd65536));    // top of interval
        send_item(make_enc(16'd0, 17'd0, 17'd0));           // zero total, ignored
        send_item(make_enc(16'd1, 17'd65536, 17'd1));       // out of range, wraps
        send_item(make_enc(16'd0, 17'h1ffff, 17'h1ffff));   // widest fields
        send_item(make_op(2'd3));                           // unknown, ignored
        send_item(make_enc(16'd2, 17'd1, 17'd3));           // last interval rule
        send_item(make_enc(16'd0, 17'd1, 17'd2));
        send_item(make_op(rebr_pkg::OP_FINISH));
        send_item(make_op(rebr_pkg::OP_FINISH));            // finish twice
        drain();
        write_cfg(rebr_pkg::CFG_FAST_MODE, 32'd1);
        write_cfg(rebr_pkg::CFG_FIRST_BYTE, 32'h00);
        write_cfg(rebr_pkg::CFG_INITIAL_COUNT, 32'd0);
        send_item(make_op(rebr_pkg::OP_START));
        // long pending runs: stay just below the carry boundary
        for (int i = 0; i < 6; i++) send_item(make_enc(16'd65534, 17'd1, 17'd65536));
        send_item(make_enc(16'd1, 17'd65535, 17'd65536));
        send_item(make_op(rebr_pkg::OP_FINISH));
        drain();
    endtask

    task automatic test_random(input int n_items);
        int left;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(make_op(2'($urandom_range(0, 3))));   // noise
            end else begin
                send_item(make_op(rebr_pkg::OP_START));
                repeat ($urandom_range(1, 12)) begin
                    send_item(rand_symbol());
                    left--;
                    send_gap();
                end
                send_item(make_op(rebr_pkg::OP_FINISH));
            end
            left--;
            send_gap();
        end
        drain();
    endtask

    task automatic test_config_sweep();
        write_cfg(rebr_pkg::CFG_FAST_MODE, 32'($urandom_range(0, 1)));
        write_cfg(rebr_pkg::CFG_FIRST_BYTE, $urandom);
        write_cfg(rebr_pkg::CFG_INITIAL_COUNT, $urandom);
        test_random(30);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        send_item(make_op(rebr_pkg::OP_START));
        for (int i = 0; i < 8; i++) send_item(make_enc(16'd0, 17'd1, 17'd65536));
        send_item(make_op(rebr_pkg::OP_FINISH));
        hold_off = 1'b0;
        drain();
    endtask

    // Receiver stall pattern: free stretches, random stalls and long hold-offs on request.
    initial begin
        int hold;
        i_stall = 1'b1;
        rx_free = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_stall <= 1'b1;
                hold = 0;
                while (hold < 600) begin
                    @(posedge i_clk);
                    hold++;
                end
                i_stall <= 1'b0;
                while (hold_off) @(posedge i_clk);
            end else if (rx_free) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) == 0) rx_free = ~rx_free;
        end
    end

    // Result checker: compare each accepted transaction with the oldest expectation.
    always @(posedge i_clk) begin
        rebr_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_runs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h", o_data);
            end else begin
                want = expected_runs.pop_front();
                if (o_data !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: byte %h/%h run %0d/%0d last %b/%b",
                                  " ovf %b/%b cnt %h/%h"},
                                 want.byte_value, o_data.byte_value,
                                 want.run_length, o_data.run_length,
                                 want.last, o_data.last,
                                 want.pending_overflow, o_data.pending_overflow,
                                 want.bytes_written, o_data.bytes_written);
                end
            end
        end
    end

    // Watchdog on lack of progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rebr_pkg::CFG_FAST_MODE;
        i_cfg_data = '0;
        sh_fast = 1'b1; sh_first = 0; sh_init_cnt = 0;
        sh_low = 0; sh_range = rebr_pkg::TOP_VAL; sh_held = 0;
        sh_pend = 0; sh_count = 0; sh_ovf = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(70);
        test_config_sweep();
        test_config_sweep();
        drain();
        if (mismatches == 0 && expected_runs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: sim.f
design/rebr_pkg.sv
design/rebr_front.sv
design/rebr_div.sv
design/rebr_back.sv
design/range_encoder_byte_renorm_top.sv
bench/tb_top.sv
